// ===== src/lzd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

	// Field widths of a token and of an output byte
	localparam int OFFSET_W = 7;
	localparam int LENGTH_W = 6;
	localparam int BYTE_W   = 8;

	// History ring: one slot per distance that an offset can reach
	localparam int HIST_DEPTH = 128;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_LIT
	} lzd_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // latch the token on the input transfer
		logic rd_en;      // read the history slot at the copy pointer
		logic push_copy;  // emit the copied byte and store it
		logic push_lit;   // emit the literal and store it
	} lzd_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic tok_copy;   // incoming token has a copy to make
		logic tok_lit;    // incoming token has a literal
		logic has_lit;    // latched token has a literal
		logic last_copy;  // one copy byte left
		logic out_free;   // output register can take a byte this cycle
	} lzd_sts_t;

endpackage

`default_nettype wire

// ===== src/lzd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/lzd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              token_valid,
	input  wire lzd_pkg::lzd_sts_t sts,
	output lzd_pkg::lzd_cmd_t      cmd,
	output logic                   busy
);

	lzd_pkg::lzd_state_t state_q;
	lzd_pkg::lzd_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			lzd_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (token_valid) begin
					cmd.load = 1'b1;
					if (sts.tok_copy) begin
						state_d = lzd_pkg::ST_READ;
					end else if (sts.tok_lit) begin
						state_d = lzd_pkg::ST_LIT;
					end
				end
			end
			lzd_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = lzd_pkg::ST_COPY;
			end
			lzd_pkg::ST_COPY: begin
				if (sts.out_free) begin
					cmd.push_copy = 1'b1;
					if (!sts.last_copy) begin
						state_d = lzd_pkg::ST_READ;
					end else if (sts.has_lit) begin
						state_d = lzd_pkg::ST_LIT;
					end else begin
						state_d = lzd_pkg::ST_IDLE;
					end
				end
			end
			lzd_pkg::ST_LIT: begin
				if (sts.out_free) begin
					cmd.push_lit = 1'b1;
					state_d      = lzd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/lzd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lzd_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lzd_pkg::OFFSET_W-1:0]    match_offset,
	input  wire logic [lzd_pkg::LENGTH_W-1:0]    match_length,
	input  wire logic [lzd_pkg::BYTE_W-1:0]      literal_byte,
	input  wire lzd_pkg::lzd_cmd_t               cmd,
	output lzd_pkg::lzd_sts_t                    sts,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic      [lzd_pkg::BYTE_W-1:0]      out_byte,
	output logic                                 token_end
);

	logic [lzd_pkg::HIST_AW-1:0]    wp_q;
	logic [lzd_pkg::HIST_AW-1:0]    rd_q;
	logic [lzd_pkg::LENGTH_W-1:0]   cnt_q;
	logic [lzd_pkg::BYTE_W-1:0]     lit_q;
	logic [lzd_pkg::HIST_DEPTH-1:0] written_q;
	logic                           rvld_q;
	logic                           out_valid_q;
	logic [lzd_pkg::BYTE_W-1:0]     out_byte_q;
	logic                           token_end_q;
	logic [lzd_pkg::BYTE_W-1:0]     ram_rdata;
	logic [lzd_pkg::BYTE_W-1:0]     copy_byte;
	logic                           push;
	logic [lzd_pkg::BYTE_W-1:0]     wr_byte;

	// A slot never written since reset reads as zero
	assign copy_byte = rvld_q ? ram_rdata : '0;
	assign push      = cmd.push_copy | cmd.push_lit;
	assign wr_byte   = cmd.push_lit ? lit_q : copy_byte;

	// Status for the controller
	always_comb begin
		sts.tok_copy  = (match_offset != '0) && (match_length != '0);
		sts.tok_lit   = (literal_byte != '0);
		sts.has_lit   = (lit_q != '0);
		sts.last_copy = (cnt_q == lzd_pkg::LENGTH_W'(1));
		sts.out_free  = !out_valid_q || !result_stall;
	end

	// Latch the token, advance the pointers as bytes go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (push) begin
			wp_q <= wp_q + lzd_pkg::HIST_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q  <= wp_q - lzd_pkg::HIST_AW'(match_offset);
			cnt_q <= match_length;
			lit_q <= literal_byte;
		end else if (cmd.push_copy) begin
			rd_q  <= rd_q + lzd_pkg::HIST_AW'(1);
			cnt_q <= cnt_q - lzd_pkg::LENGTH_W'(1);
		end
	end

	// Mark each history slot once it has been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvld_q    <= 1'b0;
		end else begin
			if (push) begin
				written_q[wp_q] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rvld_q <= written_q[rd_q];
			end
		end
	end

	lzd_ram #(
		.WIDTH(lzd_pkg::BYTE_W),
		.DEPTH(lzd_pkg::HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (push),
		.waddr(wp_q),
		.wdata(wr_byte),
		.re   (cmd.rd_en),
		.raddr(rd_q),
		.rdata(ram_rdata)
	);

	// Output register: load on push, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_byte_q  <= wr_byte;
			token_end_q <= cmd.push_lit | (sts.last_copy & ~sts.has_lit);
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign token_end    = token_end_q;

endmodule

`default_nettype wire

// ===== src/lz77_token_decoder.sv =====
// A copied byte passes the history RAM read in ST_READ, then is pushed in ST_COPY into the
// output register; a literal with no copy is pushed in ST_LIT straight into that register.
// The input stays stalled until the controller is back in ST_IDLE, and a push waits while
// the output register is full; each copied byte is a history RAM read then a write.
// Reset clears the controller, write pointer, output register and the
// per-slot written flags, so every history slot reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module lz77_token_decoder (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         token_valid,
	output logic                              token_stall,
	input  wire logic [lzd_pkg::OFFSET_W-1:0] match_offset,
	input  wire logic [lzd_pkg::LENGTH_W-1:0] match_length,
	input  wire logic [lzd_pkg::BYTE_W-1:0]   literal_byte,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic      [lzd_pkg::BYTE_W-1:0]   out_byte,
	output logic                              token_end
);

	lzd_pkg::lzd_cmd_t cmd;
	lzd_pkg::lzd_sts_t sts;
	logic              busy;

	assign token_stall = busy;

	lzd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.token_valid(token_valid),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	lzd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.match_offset(match_offset),
		.match_length(match_length),
		.literal_byte(literal_byte),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.out_byte    (out_byte),
		.token_end   (token_end)
	);

	// At most one command a cycle
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.rd_en, cmd.push_copy, cmd.push_lit}))
		else $error("more than one datapath command at once");

	// A byte is pushed only when the output register has room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_copy || cmd.push_lit) |-> sts.out_free)
		else $error("byte pushed into a full output register");

	// A pushed byte is offered in the next cycle
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_copy || cmd.push_lit) |=> result_valid)
		else $error("pushed byte not offered");

	// A token with a literal keeps the input stalled while it is worked off
	a_lit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !token_stall && literal_byte != '0) |=> token_stall)
		else $error("input free while a literal is pending");

endmodule

`default_nettype wire

// ===== sim/lz77_token_checker.sv =====
`timescale 1ns / 1ps

module lz77_token_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         token_valid,
	input  wire logic                         token_stall,
	input  wire logic [lzd_pkg::OFFSET_W-1:0] match_offset,
	input  wire logic [lzd_pkg::LENGTH_W-1:0] match_length,
	input  wire logic [lzd_pkg::BYTE_W-1:0]   literal_byte,
	input  wire logic                         result_valid,
	input  wire logic                         result_stall,
	input  wire logic [lzd_pkg::BYTE_W-1:0]   out_byte,
	input  wire logic                         token_end,
	output int                                error_count,
	output int                                bytes_pending
);
	import lzd_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} out_beat_t;

	// Own copy of the decoder state: produced-output window and next slot
	logic [BYTE_W-1:0]  window_bytes [HIST_DEPTH];
	logic [HIST_AW-1:0] next_slot;
	out_beat_t          decoded_q [$];

	// Expand one token into the bytes it must produce, updating the window
	task automatic decode_token(input logic [OFFSET_W-1:0] off,
			input logic [LENGTH_W-1:0] len, input logic [BYTE_W-1:0] lit);
		logic [HIST_AW-1:0] rd;
		logic [BYTE_W-1:0]  b;
		int                 copies;
		int                 total;
		out_beat_t          beat;
		copies = (off == '0) ? 0 : int'(len);
		total  = copies + ((lit != '0) ? 1 : 0);
		rd     = next_slot - HIST_AW'(off);
		// copy one byte at a time so overlapping matches repeat fresh output
		for (int i = 0; i < copies; i++) begin
			b = window_bytes[rd];
			rd++;
			window_bytes[next_slot] = b;
			next_slot++;
			beat.data = b;
			beat.last = (i + 1 == total);
			decoded_q.insert(decoded_q.size(), beat);
		end
		if (lit != '0) begin
			window_bytes[next_slot] = lit;
			next_slot++;
			beat.data = lit;
			beat.last = 1'b1;
			decoded_q.insert(decoded_q.size(), beat);
		end
	endtask

	// Check each output transfer against the oldest expected byte, then
	// predict from any token transfer on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++)
				window_bytes[i] = '0;
			next_slot = '0;
			decoded_q.delete();
			error_count = 0;
			bytes_pending = 0;
		end else begin : watch
			out_beat_t want;
			if (result_valid && !result_stall) begin
				if (decoded_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected output: expected none, got out_byte %h token_end %b",
						$time, out_byte, token_end);
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.data) begin
						error_count++;
						$display("%0t: out_byte: expected %h, got %h",
							$time, want.data, out_byte);
					end
					if (token_end !== want.last) begin
						error_count++;
						$display("%0t: token_end: expected %b, got %b",
							$time, want.last, token_end);
					end
				end
			end
			if (token_valid && !token_stall)
				decode_token(match_offset, match_length, literal_byte);
			bytes_pending = decoded_q.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lzd_pkg::*;

	localparam int N_TOKENS     = 270;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                token_valid  = 1'b0;
	logic                token_stall;
	logic [OFFSET_W-1:0] match_offset = '0;
	logic [LENGTH_W-1:0] match_length = '0;
	logic [BYTE_W-1:0]   literal_byte = '0;
	logic                result_valid;
	logic                result_stall;
	logic [BYTE_W-1:0]   out_byte;
	logic                token_end;
	logic                rx_stall     = 1'b0;
	logic                hold_off     = 1'b0;
	logic                tx_quiet     = 1'b0;
	int                  tokens_sent  = 0;
	int                  error_count;
	int                  bytes_pending;

	assign result_stall = rx_stall | hold_off;

	always #6 clk = ~clk;

	lz77_token_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.match_offset (match_offset),
		.match_length (match_length),
		.literal_byte (literal_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.token_end    (token_end)
	);

	lz77_token_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.token_valid   (token_valid),
		.token_stall   (token_stall),
		.match_offset  (match_offset),
		.match_length  (match_length),
		.literal_byte  (literal_byte),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_byte      (out_byte),
		.token_end     (token_end),
		.error_count   (error_count),
		.bytes_pending (bytes_pending)
	);

	// Offer one token after a random gap and hold it until the transfer
	task automatic offer_token(input logic [OFFSET_W-1:0] off,
			input logic [LENGTH_W-1:0] len, input logic [BYTE_W-1:0] lit);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			token_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		token_valid  <= 1'b1;
		match_offset <= off;
		match_length <= len;
		literal_byte <= lit;
		@(posedge clk);
		while (token_stall)
			@(posedge clk);
		tokens_sent++;
		@(negedge clk);
	endtask

	// Reset, directed tokens, random tokens, drain and verdict
	initial begin
		logic [OFFSET_W-1:0] off;
		logic [LENGTH_W-1:0] len;
		logic [BYTE_W-1:0]   lit;
		int                  pick;
		int                  n_real;
		int                  n_drawn;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// read never-written slots, then empty and copy-free tokens
		offer_token(7'd5,   6'd3,  8'h41);
		offer_token(7'd0,   6'd63, 8'h7f);
		offer_token(7'd0,   6'd0,  8'h00);
		offer_token(7'd0,   6'd10, 8'h00);
		offer_token(7'd0,   6'd0,  8'hff);
		offer_token(7'd0,   6'd0,  8'h01);
		offer_token(7'd0,   6'd0,  8'h80);
		// overlapping copies, literal and no literal
		offer_token(7'd1,   6'd20, 8'h55);
		offer_token(7'd3,   6'd63, 8'h00);
		offer_token(7'd2,   6'd0,  8'h33);
		offer_token(7'd1,   6'd1,  8'h00);
		// longest reach back, wrapping the window
		offer_token(7'd127, 6'd63, 8'haa);
		offer_token(7'd127, 6'd1,  8'h00);
		offer_token(7'd64,  6'd5,  8'h2a);
		offer_token(7'd100, 6'd63, 8'hff);
		offer_token(7'd127, 6'd0,  8'h00);
		offer_token(7'd8,   6'd8,  8'h01);

		// random tokens, mostly short matches against recent output
		n_real  = 0;
		n_drawn = 0;
		while (n_real < N_TOKENS) begin
			if (n_drawn % 32 == 0)
				tx_quiet = ($urandom_range(0, 3) == 0);
			n_drawn++;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				off = '0;
			else if (pick < 60)
				off = OFFSET_W'($urandom_range(1, 16));
			else if (pick < 85)
				off = OFFSET_W'($urandom_range(1, 127));
			else
				off = OFFSET_W'($urandom_range(64, 127));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = LENGTH_W'($urandom_range(0, 8));
			else if (pick < 90)
				len = LENGTH_W'($urandom_range(9, 20));
			else
				len = LENGTH_W'($urandom_range(21, 63));
			pick = $urandom_range(0, 99);
			if (pick < 15)
				lit = '0;
			else if (pick < 20)
				lit = 8'hff;
			else
				lit = BYTE_W'($urandom_range(1, 255));
			offer_token(off, len, lit);
			if ((off != '0 && len != '0) || lit != '0)
				n_real++;
		end
		token_valid <= 1'b0;

		// drain, then allow the block's latency to pass
		while (bytes_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && bytes_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Accept output bytes after a random stall, with quiet stretches
	initial begin
		int  gap;
		int  beats;
		logic rx_quiet;
		beats    = 0;
		rx_quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (beats % 40 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			gap = rx_quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				rx_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rx_stall <= 1'b0;
			@(posedge clk);
			while (!(result_valid && !result_stall))
				@(posedge clk);
			beats++;
			@(negedge clk);
		end
	end

	// Hold the output off for a long stretch so the block backs up its input
	initial begin
		wait (tokens_sent >= 60);
		@(negedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_off <= 1'b0;
	end

	// Give up after a generous bound
	initial begin
		#12_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/lzd_pkg.sv
src/lzd_ram.sv
src/lzd_ctrl.sv
src/lzd_datapath.sv
src/lz77_token_decoder.sv
sim/lz77_token_checker.sv
sim/testbench.sv
